// ===== hw/rtl/greedy_mooring_scheduler_top_macros.svh =====
`ifndef GREEDY_MOORING_SCHEDULER_TOP_MACROS_SVH
`define GREEDY_MOORING_SCHEDULER_TOP_MACROS_SVH

// The antecedent implies the consequent in the next cycle.
`define GMS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mooring scheduler: next-cycle check failed");

// The antecedent implies the consequent in the same cycle.
`define GMS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mooring scheduler: same-cycle check failed");

`endif

// ===== hw/rtl/gms_pkg.sv =====
package gms_pkg;

    localparam int ANCHOR_W = 25;
    localparam int LENGTH_W = 24;
    localparam int EDGE_W   = 26;
    localparam int SUM_W    = 27;
    localparam int PLACED_W = 11;

    typedef struct packed {
        logic signed [ANCHOR_W-1:0] anchor;
        logic [LENGTH_W-1:0]        len;
    } boat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SORT_RD,
        ST_SORT_KEY,
        ST_SORT_CMP,
        ST_SORT_PUT,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_DONE
    } state_t;

endpackage

// ===== hw/rtl/greedy_mooring_scheduler_top.sv =====
// Loading: one boat per cycle; busy stays low until the transaction flagged as last.
// After the last boat, a stable insertion sort runs over the n stored boats,
// then the greedy scan runs over them, then the result strobe shows for one cycle.
// The single-port-read boat memory bounds the rate; the receiver cannot stall the strobe.
// Reset (asynchronous, active low) clears the count, the overflow flag and the controller.
module greedy_mooring_scheduler_top
    import gms_pkg::*;
#(
    parameter int MAX_BOATS = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [ANCHOR_W-1:0] anchor_position,
    input  logic [LENGTH_W-1:0]        boat_length,
    input  logic                       last_boat,
    output logic                       result_valid,
    output logic [PLACED_W-1:0]        boats_placed,
    output logic                       capacity_overflow
);

    localparam int CNT_W  = $clog2(MAX_BOATS + 1);
    localparam int ADDR_W = $clog2(MAX_BOATS);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BOATS);
    localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);
    localparam logic [CNT_W-1:0] TWO     = CNT_W'(2);

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic overflow_reg, overflow_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    boat_t key_reg, key_next;
    logic [CNT_W-1:0] placed_reg, placed_next;
    logic signed [EDGE_W-1:0] edge_reg, edge_next;
    logic signed [EDGE_W-1:0] pending_reg, pending_next;
    logic group_reg, group_next;
    logic first_reg, first_next;

    boat_t mem [MAX_BOATS];
    boat_t rdata_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic wr_en;
    logic [ADDR_W-1:0] wr_addr;
    boat_t wr_data;

    logic signed [SUM_W-1:0] anchor_ext;
    logic signed [SUM_W-1:0] edge_sum;
    logic signed [SUM_W-1:0] boat_end;
    logic signed [SUM_W-1:0] pending_ext;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            i_reg        <= '0;
            j_reg        <= '0;
            placed_reg   <= '0;
            group_reg    <= 1'b0;
            first_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            placed_reg   <= placed_next;
            group_reg    <= group_next;
            first_reg    <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        edge_reg    <= edge_next;
        pending_reg <= pending_next;
    end

    // End of the boat just read when it follows the current right edge.
    assign anchor_ext  = SUM_W'(rdata_reg.anchor);
    assign edge_sum    = SUM_W'(edge_reg) + $signed({3'b000, rdata_reg.len});
    assign boat_end    = (edge_sum > anchor_ext) ? edge_sum : anchor_ext;
    assign pending_ext = SUM_W'(pending_reg);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        overflow_next = overflow_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        key_next      = key_reg;
        placed_next   = placed_reg;
        edge_next     = edge_reg;
        pending_next  = pending_reg;
        group_next    = group_reg;
        first_next    = first_reg;
        rd_addr       = i_reg[ADDR_W-1:0];
        wr_en         = 1'b0;
        wr_addr       = count_reg[ADDR_W-1:0];
        wr_data       = '{anchor: anchor_position, len: boat_length};

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (count_reg < MAX_CNT)
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + ONE;
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                    if (last_boat)
                    begin
                        i_next     = ONE;
                        state_next = ST_SORT_RD;
                    end
                end
            end
            ST_SORT_RD:
            begin
                if (i_reg >= count_reg)
                begin
                    i_next      = '0;
                    placed_next = '0;
                    group_next  = 1'b0;
                    first_next  = 1'b1;
                    state_next  = ST_SCAN_RD;
                end
                else
                begin
                    state_next = ST_SORT_KEY;
                end
            end
            ST_SORT_KEY:
            begin
                key_next   = rdata_reg;
                j_next     = i_reg;
                rd_addr    = ADDR_W'(i_reg - ONE);
                state_next = ST_SORT_CMP;
            end
            ST_SORT_CMP:
            begin
                // rdata holds entry j-1; shift it up while it is strictly larger.
                wr_en   = 1'b1;
                wr_addr = j_reg[ADDR_W-1:0];
                if (rdata_reg.anchor > key_reg.anchor)
                begin
                    wr_data = rdata_reg;
                    j_next  = j_reg - ONE;
                    if (j_reg >= TWO)
                    begin
                        rd_addr = ADDR_W'(j_reg - TWO);
                    end
                    else
                    begin
                        state_next = ST_SORT_PUT;
                    end
                end
                else
                begin
                    wr_data    = key_reg;
                    i_next     = i_reg + ONE;
                    state_next = ST_SORT_RD;
                end
            end
            ST_SORT_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = j_reg[ADDR_W-1:0];
                wr_data    = key_reg;
                i_next     = i_reg + ONE;
                state_next = ST_SORT_RD;
            end
            ST_SCAN_RD:
            begin
                if (i_reg >= count_reg)
                begin
                    if (group_reg)
                    begin
                        placed_next = placed_reg + ONE;
                    end
                    group_next = 1'b0;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_SCAN_EV;
                end
            end
            ST_SCAN_EV:
            begin
                state_next = ST_SCAN_RD;
                if (first_reg)
                begin
                    first_next  = 1'b0;
                    edge_next   = EDGE_W'(rdata_reg.anchor);
                    placed_next = ONE;
                    i_next      = i_reg + ONE;
                end
                else if (group_reg)
                begin
                    if (pending_ext > anchor_ext)
                    begin
                        if (boat_end < pending_ext)
                        begin
                            pending_next = boat_end[EDGE_W-1:0];
                        end
                        i_next = i_reg + ONE;
                    end
                    else
                    begin
                        // Group closes; this boat is looked at again as a fresh start.
                        edge_next   = pending_reg;
                        placed_next = placed_reg + ONE;
                        group_next  = 1'b0;
                    end
                end
                else if (edge_sum > anchor_ext)
                begin
                    group_next   = 1'b1;
                    pending_next = boat_end[EDGE_W-1:0];
                    i_next       = i_reg + ONE;
                end
                else
                begin
                    edge_next   = EDGE_W'(rdata_reg.anchor);
                    placed_next = placed_reg + ONE;
                    i_next      = i_reg + ONE;
                end
            end
            ST_DONE:
            begin
                count_next    = '0;
                overflow_next = 1'b0;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy              = (state_reg != ST_IDLE);
    assign result_valid      = (state_reg == ST_DONE);
    assign boats_placed      = PLACED_W'(placed_reg);
    assign capacity_overflow = overflow_reg;

endmodule

// ===== hw/rtl/gms_checker.sv =====
`include "greedy_mooring_scheduler_top_macros.svh"

module gms_assertions
    import gms_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       last_boat,
    input logic                       result_valid,
    input logic [PLACED_W-1:0]        boats_placed,
    input logic                       capacity_overflow
);

    // A last boat starts the sort and scan, which locks out new transactions.
    `GMS_ASSERT_NEXT(a_last_sets_busy, start && !busy && last_boat, busy)
    // The strobe lasts exactly one cycle and frees the input right after.
    `GMS_ASSERT_NEXT(a_strobe_single, result_valid, !result_valid && !busy)
    // No result appears while the block is open for loading.
    `GMS_ASSERT_SAME(a_no_result_idle, !busy, !result_valid)
    // A boat that is not the last never produces a result in the next cycle.
    `GMS_ASSERT_NEXT(a_plain_no_result, start && !busy && !last_boat, !result_valid)
    // A strobed result carries only known bits.
    `GMS_ASSERT_SAME(a_result_known, result_valid,
                     !$isunknown({boats_placed, capacity_overflow}))

endmodule

bind greedy_mooring_scheduler_top gms_assertions u_gms_assertions (.*);
